@@ src/utf8_stream_decoder_macros.svh @@
// Assertion macros for the decoder top level.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define UTF8D_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define UTF8D_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/utf8d_pkg.sv @@
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;

  localparam logic [LEN_W-1:0] LEN_IDLE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             ok;
    logic             last_of_run;
  } result_t;

  // What one accepted byte produces: up to two results, in order.
  typedef struct packed {
    result_t    first;
    result_t    second;
    logic [1:0] count;
  } decode_t;

endpackage

@@ src/utf8d_byte_if.sv @@
`timescale 1ns / 1ps

interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

@@ src/utf8d_result_if.sv @@
`timescale 1ns / 1ps

interface utf8d_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  seq_length;
  logic        ok;
  logic        last_of_run;

  modport source (output valid, output code_point, output seq_length, output ok,
                  output last_of_run, input ready);
  modport sink (input valid, input code_point, input seq_length, input ok,
                input last_of_run, output ready);
endinterface

@@ src/utf8d_core.sv @@
`timescale 1ns / 1ps

module utf8d_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         byte_in,
  output utf8d_pkg::decode_t dec
);
  import utf8d_pkg::*;

  typedef struct packed {
    logic             emit;
    result_t          res;
    logic [CP_W-1:0]  pv;
    logic [LEN_W-1:0] len;
  } lead_t;

  logic [CP_W-1:0]  partial_value, partial_value_next;
  logic [LEN_W-1:0] expected_length, expected_length_next;
  logic [LEN_W-1:0] bytes_seen, bytes_seen_next;
  logic [LEN_W-1:0] seen_inc;
  lead_t            lead;

  function automatic result_t error_result(input logic [LEN_W-1:0] len);
    result_t r;
    r.code_point  = '0;
    r.seq_length  = len;
    r.ok          = 1'b0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic lead_t decode_lead(input logic [7:0] b);
    lead_t l;
    l.emit = 1'b0;
    l.res  = error_result(LEN_ONE);
    l.pv   = '0;
    l.len  = LEN_IDLE;
    if (b[7] == 1'b0) begin
      l.emit           = 1'b1;
      l.res.code_point = {{(CP_W-8){1'b0}}, b};
      l.res.ok         = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      if (b[4:1] == 4'd0) begin
        l.emit = 1'b1;
      end else begin
        l.pv  = {{(CP_W-5){1'b0}}, b[4:0]};
        l.len = LEN_TWO;
      end
    end else if (b[7:4] == 4'b1110) begin
      l.pv  = {{(CP_W-4){1'b0}}, b[3:0]};
      l.len = LEN_THREE;
    end else if (b[7:3] == 5'b11110) begin
      l.pv  = {{(CP_W-3){1'b0}}, b[2:0]};
      l.len = LEN_FOUR;
    end else begin
      l.emit = 1'b1;
    end
    return l;
  endfunction

  assign lead     = decode_lead(byte_in);
  assign seen_inc = bytes_seen + LEN_ONE;

  always_comb begin
    partial_value_next   = partial_value;
    expected_length_next = expected_length;
    bytes_seen_next      = bytes_seen;
    dec.first            = error_result(LEN_ONE);
    dec.second           = error_result(LEN_ONE);
    dec.count            = 2'd0;
    if (expected_length == LEN_IDLE) begin
      dec.first             = lead.res;
      dec.first.last_of_run = 1'b1;
      dec.count             = {1'b0, lead.emit};
      partial_value_next    = lead.pv;
      expected_length_next  = lead.len;
      bytes_seen_next       = lead.emit ? LEN_IDLE : LEN_ONE;
    end else if (byte_in[7:6] == 2'b10) begin
      partial_value_next = {partial_value[CP_W-7:0], byte_in[5:0]};
      bytes_seen_next    = seen_inc;
      if (seen_inc >= expected_length) begin
        dec.first.code_point  = partial_value_next;
        dec.first.seq_length  = expected_length;
        dec.first.ok          = 1'b1;
        dec.first.last_of_run = 1'b1;
        dec.count             = 2'd1;
        partial_value_next    = '0;
        expected_length_next  = LEN_IDLE;
        bytes_seen_next       = LEN_IDLE;
      end
    end else begin
      // The abandoned sequence is reported first, then the byte starts over.
      dec.first             = error_result(bytes_seen);
      dec.first.last_of_run = !lead.emit;
      dec.second            = lead.res;
      dec.second.last_of_run = 1'b1;
      dec.count             = lead.emit ? 2'd2 : 2'd1;
      partial_value_next    = lead.pv;
      expected_length_next  = lead.len;
      bytes_seen_next       = lead.emit ? LEN_IDLE : LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      expected_length <= LEN_IDLE;
      bytes_seen      <= LEN_IDLE;
    end else if (take) begin
      partial_value   <= partial_value_next;
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
    end
  end

endmodule

@@ src/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// Channel       Direction  Payload
// byte_stream   in         byte_in[7:0]
// results       out        code_point[20:0], seq_length[2:0], ok, last_of_run
//
// One byte is taken per cycle while the byte side is ready; the decode settles in the cycle it is taken.
// Results wait in a four-entry queue; the byte side is ready while it holds two or fewer.
// A byte that ends a sequence early gives an error result, plus a second one if it opens no new sequence.
// Synchronous rst clears the decoder state and empties the queue.

module utf8_stream_decoder (
  input  logic                  clk,
  input  logic                  rst,
  utf8d_byte_if.sink            byte_stream,
  utf8d_result_if.source        results
);
  import utf8d_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  result_t          queue [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count, count_next;
  logic             accept, pop;
  logic [1:0]       push_n;
  decode_t          dec;

  assign byte_stream.ready = (count <= CNT_W'(DEPTH - 2));
  assign accept            = byte_stream.valid && byte_stream.ready;
  assign results.valid     = (count != '0);
  assign pop               = results.valid && results.ready;
  assign push_n            = accept ? dec.count : 2'd0;
  assign count_next        = count + CNT_W'(push_n) - CNT_W'(pop);

  assign results.code_point  = queue[head].code_point;
  assign results.seq_length  = queue[head].seq_length;
  assign results.ok          = queue[head].ok;
  assign results.last_of_run = queue[head].last_of_run;

  utf8d_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (accept),
    .byte_in (byte_stream.byte_in),
    .dec     (dec)
  );

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[tail] <= dec.first;
    end
    if (push_n == 2'd2) begin
      queue[tail + PTR_W'(1)] <= dec.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PTR_W'(pop);
      tail  <= tail + PTR_W'(push_n);
      count <= count_next;
    end
  end

`include "utf8_stream_decoder_macros.svh"

  `UTF8D_CHECK(a_queue_bound, count <= CNT_W'(DEPTH), "result queue overflow")
  `UTF8D_CHECK(a_error_zero, !(results.valid && !results.ok) || results.code_point == '0, "error item with nonzero code point")
  `UTF8D_CHECK(a_len_range, !results.valid || (results.seq_length != 3'd0 && results.seq_length <= LEN_FOUR), "item length out of range")
  `UTF8D_CHECK_NEXT(a_empty_stays, count == '0 && !accept, !results.valid, "item appeared without a byte")

endmodule

@@ test/utf8_decode_checker.sv @@
`timescale 1ns / 1ps

module utf8_decode_checker (
  input  logic        clk,
  input  logic        rst,
  utf8d_byte_if       byte_stream,
  utf8d_result_if     results,
  output int unsigned error_count,
  output int unsigned pending
);
  import utf8d_pkg::*;

  logic [CP_W-1:0]  cp_acc;
  logic [LEN_W-1:0] open_len;
  logic [LEN_W-1:0] bytes_in;
  result_t          expected_q[$];

  initial begin
    error_count = 0;
    pending = 0;
  end

  task automatic add_result(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                            input logic good);
    result_t r;
    r.code_point  = cp;
    r.seq_length  = len;
    r.ok          = good;
    r.last_of_run = 1'b0;
    expected_q.push_back(r);
  endtask

  task automatic close_sequence();
    cp_acc   = '0;
    open_len = LEN_IDLE;
    bytes_in = '0;
  endtask

  task automatic take_lead(input logic [7:0] b);
    if (!b[7]) begin
      add_result(CP_W'(b), LEN_ONE, 1'b1);
    end else if (b[7:5] == 3'b110 && b[4:1] != 4'd0) begin
      cp_acc   = CP_W'(b[4:0]);
      open_len = LEN_TWO;
      bytes_in = LEN_ONE;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc   = CP_W'(b[3:0]);
      open_len = LEN_THREE;
      bytes_in = LEN_ONE;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc   = CP_W'(b[2:0]);
      open_len = LEN_FOUR;
      bytes_in = LEN_ONE;
    end else begin
      add_result('0, LEN_ONE, 1'b0);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    int unsigned queued;
    queued = expected_q.size();
    if (open_len == LEN_IDLE) begin
      take_lead(b);
    end else if (b[7:6] == 2'b10) begin
      cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
      bytes_in = bytes_in + LEN_ONE;
      if (bytes_in >= open_len) begin
        add_result(cp_acc, open_len, 1'b1);
        close_sequence();
      end
    end else begin
      // The abandoned sequence is reported first, then the byte starts over as a lead.
      add_result('0, bytes_in, 1'b0);
      close_sequence();
      take_lead(b);
    end
    if (expected_q.size() > queued) begin
      expected_q[expected_q.size()-1].last_of_run = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] decode mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result cp=%h len=%0d ok=%b last=%b",
                                results.code_point, results.seq_length, results.ok,
                                results.last_of_run));
      return;
    end
    want = expected_q.pop_front();
    if (results.code_point !== want.code_point) begin
      report_mismatch($sformatf("code_point %h, expected %h",
                                results.code_point, want.code_point));
    end
    if (results.seq_length !== want.seq_length) begin
      report_mismatch($sformatf("seq_length %0d, expected %0d",
                                results.seq_length, want.seq_length));
    end
    if (results.ok !== want.ok) begin
      report_mismatch($sformatf("ok %b, expected %b", results.ok, want.ok));
    end
    if (results.last_of_run !== want.last_of_run) begin
      report_mismatch($sformatf("last_of_run %b, expected %b",
                                results.last_of_run, want.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      close_sequence();
      expected_q.delete();
    end else begin
      if (byte_stream.valid && byte_stream.ready) begin
        predict_byte(byte_stream.byte_in);
      end
      if (results.valid && results.ready) begin
        check_result();
      end
    end
    pending <= expected_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycles = 0;
  int unsigned error_count;
  int unsigned pending;
  int unsigned sent = 0;
  int unsigned sink_hold = 0;
  bit          no_stalls = 1'b0;

  utf8d_byte_if   byte_stream ();
  utf8d_result_if results ();

  utf8_stream_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .results     (results)
  );

  utf8_decode_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .results     (results),
    .error_count (error_count),
    .pending     (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_stalls || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      results.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      results.ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) begin
        sink_hold = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_stream.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_stream.valid   <= 1'b1;
    byte_stream.byte_in <= b;
    do @(posedge clk); while (!byte_stream.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_char(input int unsigned len, input bit cut_short);
    logic [7:0]  lead;
    int unsigned count;
    case (len)
      1: lead = 8'($urandom_range(8'h00, 8'h7F));
      2: lead = 8'($urandom_range(8'hC2, 8'hDF));
      3: lead = 8'($urandom_range(8'hE0, 8'hEF));
      default: lead = 8'($urandom_range(8'hF0, 8'hF7));
    endcase
    count = cut_short ? $urandom_range(1, len - 1) : len;
    send_byte(lead);
    repeat (count - 1) send_byte(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  task automatic drain();
    byte_stream.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    logic [7:0]  directed[] = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hC0, 8'hC1,
                                8'h80, 8'hF8, 8'hEF, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF,
                                8'hBF, 8'hF0, 8'h90, 8'h41, 8'hE2, 8'hC3, 8'hFF};
    int unsigned total;
    int unsigned pick;
    bit          paused = 1'b0;

    byte_stream.valid   = 1'b0;
    byte_stream.byte_in = 8'h00;
    results.ready       = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_byte(directed[i]);
    drain();

    total = sent + RANDOM_ITEMS;
    while (sent < total) begin
      no_stalls = ((sent / 120) % 4) == 3;
      if (!paused && sent >= total - RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_char($urandom_range(1, 4), 1'b0);
      end else if (pick < 85) begin
        send_char($urandom_range(2, 4), 1'b1);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end

    no_stalls = 1'b0;
    drain();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/utf8d_pkg.sv
src/utf8d_byte_if.sv
src/utf8d_result_if.sv
src/utf8d_core.sv
src/utf8_stream_decoder.sv
test/utf8_decode_checker.sv
test/tb_top.sv
